@@ rtl/keyed_deque_with_search_remove_assert.svh @@
// assertion macros for the keyed deque checker
`ifndef KEYED_DEQUE_WITH_SEARCH_REMOVE_ASSERT_SVH
`define KEYED_DEQUE_WITH_SEARCH_REMOVE_ASSERT_SVH
// implication checked on every edge outside reset
`define KDQ_ASSERT_IMP(lbl, clk, rst, lhs, rhs, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (lhs) |-> (rhs)) else $error(msg);
// next-cycle implication checked outside reset
`define KDQ_ASSERT_NEXT(lbl, clk, rst, lhs, rhs, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (lhs) |=> (rhs)) else $error(msg);
`endif

@@ rtl/kdq_pkg.sv @@
// ----------------------------------------------------------------------------
// kdq_pkg
// types and codes shared by the keyed deque modules
// ----------------------------------------------------------------------------
`default_nettype none
package kdq_pkg;
   localparam logic [2:0] OP_PUSH_FRONT = 3'd0;
   localparam logic [2:0] OP_PUSH_BACK  = 3'd1;
   localparam logic [2:0] OP_POP_FRONT  = 3'd2;
   localparam logic [2:0] OP_POP_BACK   = 3'd3;
   localparam logic [2:0] OP_SEARCH     = 3'd4;
   localparam logic [2:0] OP_REMOVE     = 3'd5;

   localparam logic [1:0] ST_OK       = 2'd0;
   localparam logic [1:0] ST_EMPTY    = 2'd1;
   localparam logic [1:0] ST_NOTFOUND = 2'd2;
   localparam logic [1:0] ST_FULL     = 2'd3;

   typedef struct packed {
      logic [2:0]         op;
      logic signed [31:0] ident;
      logic [63:0]        name_key;
      logic [30:0]        exec_time;
      logic [30:0]        used_time;
   } req_type;

   typedef struct packed {
      logic [1:0] status;
      logic [3:0] position;
      logic [4:0] occupancy;
   } rsp_type;

   typedef enum logic [2:0] {
      BK_IDLE, BK_SCAN, BK_READ, BK_SHIFT, BK_MOVE, BK_DONE
   } back_state_type;
endpackage
`default_nettype wire

@@ rtl/keyed_deque_with_search_remove.sv @@
// ----------------------------------------------------------------------------
// keyed_deque_with_search_remove
// bounded deque of keyed records with search and remove by key
// ----------------------------------------------------------------------------
// Usage: drive req and raise start; the request is taken when start is high
// and busy is low. One response per request appears on rsp for one cycle
// with rsp_strobe high; it cannot be held off.
// Pushes, pops and unused codes go from idle straight to the done state.
// Search and remove step through the records one position at a time via the
// single registered memory read port (a scan and a read state per position),
// ending at the first match or after the last record; remove then moves the
// following records one place each, with a shift and a move state per record.
// Only one request is in flight; busy stays high until its response is out,
// so the next request is taken in the cycle after the response at the earliest.
// Reset empties the deque (count and front slot cleared); record memory
// is not cleared, since only occupied slots are read.
// ----------------------------------------------------------------------------
`default_nettype none
module keyed_deque_with_search_remove #(
   parameter int DEPTH = 16
) (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             start,
   output logic                  busy,
   input  wire kdq_pkg::req_type req_data,
   output logic                  rsp_strobe,
   output kdq_pkg::rsp_type      rsp_data
);
   import kdq_pkg::*;

   logic    q_valid, q_take, back_busy;
   req_type q_req;

   kdq_front u_front (
      .clock, .reset, .start, .busy, .req(req_data),
      .q_valid, .q_req, .q_take, .back_busy
   );

   kdq_back #(.DEPTH(DEPTH)) u_back (
      .clock, .reset, .q_valid, .q_req, .q_take,
      .busy(back_busy), .rsp_strobe, .rsp(rsp_data)
   );
endmodule
`default_nettype wire

@@ rtl/kdq_front.sv @@
// ----------------------------------------------------------------------------
// kdq_front
// request intake with a two-entry queue towards the back end
// ----------------------------------------------------------------------------
`default_nettype none
module kdq_front (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             start,
   output logic                  busy,
   input  wire kdq_pkg::req_type req,
   output logic                  q_valid,
   output kdq_pkg::req_type      q_req,
   input  wire logic             q_take,
   input  wire logic             back_busy
);
   import kdq_pkg::*;

   req_type    slot_ff [2];
   logic       rd_ff, rd_in, wr_ff, wr_in;
   logic [1:0] cnt_ff, cnt_in;
   logic       push;

   // one request in flight overall keeps results in order and simple
   assign busy    = (cnt_ff != 2'd0) || back_busy;
   assign push    = start && !busy;
   assign q_valid = (cnt_ff != 2'd0);
   assign q_req   = slot_ff[rd_ff];

   // queue pointers
   always_comb begin
      rd_in  = rd_ff ^ q_take;
      wr_in  = wr_ff ^ push;
      cnt_in = cnt_ff + {1'b0, push} - {1'b0, q_take};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rd_ff  <= 1'b0;
         wr_ff  <= 1'b0;
         cnt_ff <= 2'd0;
      end else begin
         rd_ff  <= rd_in;
         wr_ff  <= wr_in;
         cnt_ff <= cnt_in;
      end
      if (push) slot_ff[wr_ff] <= req;
   end
endmodule
`default_nettype wire

@@ rtl/kdq_back.sv @@
// ----------------------------------------------------------------------------
// kdq_back
// sequencer that executes deque operations on the record memory
// ----------------------------------------------------------------------------
`default_nettype none
module kdq_back #(
   parameter int DEPTH = 16
) (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             q_valid,
   input  wire kdq_pkg::req_type q_req,
   output logic                  q_take,
   output logic                  busy,
   output logic                  rsp_strobe,
   output kdq_pkg::rsp_type      rsp
);
   import kdq_pkg::*;
   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CW = $clog2(DEPTH + 1);
   localparam logic [CW-1:0] FULLC = CW'(DEPTH);

   typedef struct packed {
      logic signed [31:0] ident;
      logic [63:0]        key;
      logic [30:0]        exec_t;
      logic [30:0]        used_t;
   } rec_type;

   rec_type mem [DEPTH];
   rec_type rdata_ff;

   back_state_type st_ff, st_in;
   req_type        cur_ff, cur_in;
   logic [AW-1:0]  front_ff, front_in;
   logic [CW-1:0]  cnt_ff, cnt_in;
   logic [CW-1:0]  pos_ff, pos_in;
   rsp_type        rsp_ff, rsp_in;
   logic           strobe_ff, strobe_in;
   logic           we;
   logic [AW-1:0]  waddr, raddr;
   rec_type        wdata;

   // slot of a front-relative position, modulo depth
   function automatic logic [AW-1:0] slot_of(input logic [AW-1:0] f,
                                             input logic [CW-1:0] p);
      logic [CW:0] s;
      s = {1'b0, p} + (CW+1)'(f);
      if (s >= (CW+1)'(DEPTH)) s = s - (CW+1)'(DEPTH);
      return s[AW-1:0];
   endfunction

   // busy until the response cycle is over
   assign busy       = (st_ff != BK_IDLE) || strobe_ff;
   assign rsp_strobe = strobe_ff;
   assign rsp        = rsp_ff;

   // sequencer
   always_comb begin
      st_in     = st_ff;
      cur_in    = cur_ff;
      front_in  = front_ff;
      cnt_in    = cnt_ff;
      pos_in    = pos_ff;
      rsp_in    = rsp_ff;
      strobe_in = 1'b0;
      q_take    = 1'b0;
      we        = 1'b0;
      waddr     = slot_of(front_ff, pos_ff);
      raddr     = slot_of(front_ff, pos_ff);
      wdata     = rdata_ff;
      unique case (st_ff)
         BK_IDLE: begin
            if (q_valid) begin
               q_take = 1'b1;
               cur_in = q_req;
               pos_in = '0;
               rsp_in = '{status: ST_OK, position: 4'd0, occupancy: 5'(cnt_ff)};
               st_in  = BK_DONE;
               unique case (q_req.op)
                  OP_PUSH_FRONT, OP_PUSH_BACK: begin
                     if (cnt_ff == FULLC) rsp_in.status = ST_FULL;
                     else begin
                        we    = 1'b1;
                        wdata = '{ident: q_req.ident, key: q_req.name_key,
                                  exec_t: q_req.exec_time, used_t: q_req.used_time};
                        if (q_req.op == OP_PUSH_FRONT) begin
                           front_in = (front_ff == '0) ? AW'(DEPTH - 1)
                                                       : front_ff - 1'b1;
                           waddr    = front_in;
                        end else waddr = slot_of(front_ff, cnt_ff);
                        cnt_in = cnt_ff + 1'b1;
                     end
                  end
                  OP_POP_FRONT, OP_POP_BACK: begin
                     if (cnt_ff == '0) rsp_in.status = ST_EMPTY;
                     else begin
                        cnt_in = cnt_ff - 1'b1;
                        if (cnt_in == '0) front_in = '0;
                        else if (q_req.op == OP_POP_FRONT)
                           front_in = slot_of(front_ff, CW'(1));
                     end
                  end
                  OP_SEARCH, OP_REMOVE: begin
                     if (cnt_ff == '0) rsp_in.status = ST_EMPTY;
                     else st_in = BK_SCAN;
                  end
                  default: ;
               endcase
               rsp_in.occupancy = 5'(cnt_in);
            end
         end
         BK_SCAN: begin
            // address pos issued; data lands next cycle
            st_in = BK_READ;
         end
         BK_READ: begin
            if (rdata_ff.key == cur_ff.name_key) begin
               if (cur_ff.op == OP_SEARCH) begin
                  rsp_in.position = 4'(pos_ff);
                  st_in = BK_DONE;
               end else if (pos_ff + 1'b1 >= cnt_ff) begin
                  // match is the last record, nothing to move
                  cnt_in = cnt_ff - 1'b1;
                  if (cnt_in == '0) front_in = '0;
                  rsp_in.occupancy = 5'(cnt_in);
                  st_in = BK_DONE;
               end else begin
                  pos_in = pos_ff + 1'b1;
                  st_in  = BK_SHIFT;
               end
            end else if (pos_ff + 1'b1 >= cnt_ff) begin
               rsp_in.status = ST_NOTFOUND;
               st_in = BK_DONE;
            end else begin
               pos_in = pos_ff + 1'b1;
               st_in  = BK_SCAN;
            end
         end
         BK_SHIFT: begin
            // read of the record at pos issued
            st_in = BK_MOVE;
         end
         BK_MOVE: begin
            // write the record at pos one place nearer the front
            we    = 1'b1;
            waddr = slot_of(front_ff, pos_ff - 1'b1);
            wdata = rdata_ff;
            if (pos_ff + 1'b1 >= cnt_ff) begin
               cnt_in = cnt_ff - 1'b1;
               rsp_in.occupancy = 5'(cnt_in);
               st_in  = BK_DONE;
            end else begin
               pos_in = pos_ff + 1'b1;
               st_in  = BK_SHIFT;
            end
         end
         BK_DONE: begin
            strobe_in = 1'b1;
            st_in     = BK_IDLE;
         end
         default: st_in = BK_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         st_ff     <= BK_IDLE;
         front_ff  <= '0;
         cnt_ff    <= '0;
         strobe_ff <= 1'b0;
      end else begin
         st_ff     <= st_in;
         front_ff  <= front_in;
         cnt_ff    <= cnt_in;
         strobe_ff <= strobe_in;
      end
      cur_ff <= cur_in;
      pos_ff <= pos_in;
      rsp_ff <= rsp_in;
   end

   // record memory, one write and one registered read port
   always_ff @(posedge clock) begin
      if (we) mem[waddr] <= wdata;
      rdata_ff <= mem[raddr];
   end
endmodule
`default_nettype wire

@@ rtl/kdq_checker.sv @@
// ----------------------------------------------------------------------------
// kdq_checker
// port-level checks of the keyed deque
// ----------------------------------------------------------------------------
`default_nettype none
`include "keyed_deque_with_search_remove_assert.svh"
module kdq_checker (
   input wire logic             clock,
   input wire logic             reset,
   input wire logic             start,
   input wire logic             busy,
   input wire kdq_pkg::req_type req_data,
   input wire logic             rsp_strobe,
   input wire kdq_pkg::rsp_type rsp_data
);
   import kdq_pkg::*;

   // accepted request makes the block busy
   `KDQ_ASSERT_NEXT(a_busy, clock, reset, start && !busy, busy, "not busy after request")
   // a response ends the busy period
   `KDQ_ASSERT_NEXT(a_free, clock, reset, rsp_strobe, !busy, "busy after response")
   // response only while busy
   `KDQ_ASSERT_IMP(a_resp, clock, reset, rsp_strobe, busy, "response while idle")
   // occupancy within bounds
   `KDQ_ASSERT_IMP(a_occ, clock, reset, rsp_strobe, rsp_data.occupancy <= 5'd16,
                   "occupancy out of range")
endmodule

bind keyed_deque_with_search_remove kdq_checker u_checker (.*);
`default_nettype wire
